FILE: design/fhm_pkg.sv
// Shared types and constants for the fault history log.
package fhm_pkg;

    localparam logic [7:0]  NO_ENTRY  = 8'hFF;
    localparam logic [11:0] YEAR_BASE = 12'd2012;
    localparam logic [7:0]  YEAR_MAX  = 8'hFF;

    localparam logic [2:0] MODE_RECORD = 3'd0;
    localparam logic [2:0] MODE_ERASE  = 3'd1;
    localparam logic [2:0] MODE_FIRST  = 3'd2;
    localparam logic [2:0] MODE_NEXT   = 3'd3;
    localparam logic [2:0] MODE_PREV   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_RD,
        ST_REC_A,
        ST_REC_B,
        ST_REC_C,
        ST_NAV_RD,
        ST_NAV_UPD,
        ST_OUT_RD,
        ST_OUT_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic erase;
        logic first;
        logic rd_en;
        logic rd_rec;
        logic rec_a;
        logic rec_b;
        logic rec_c;
        logic nav_upd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic id_ok;
    } sts_t;

    typedef struct packed {
        logic [7:0]  year_offset;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [7:0]  floor_code;
        logic [7:0]  drive_state;
        logic [15:0] current_d;
        logic [15:0] current_q;
    } rec_t;

endpackage

FILE: design/fhm_ctrl.sv
// Sequencer for record, erase and browse items of the fault history log.
module fhm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        mode,
    input  fhm_pkg::sts_t     sts,
    output logic              busy,
    output fhm_pkg::cmd_t     cmd
);

    fhm_pkg::state_t state_reg;
    fhm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fhm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fhm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        fhm_pkg::MODE_RECORD:
                        begin
                            if (sts.id_ok)
                            begin
                                state_next = fhm_pkg::ST_REC_RD;
                            end
                        end
                        fhm_pkg::MODE_FIRST: state_next = fhm_pkg::ST_OUT_RD;
                        fhm_pkg::MODE_NEXT:  state_next = fhm_pkg::ST_NAV_RD;
                        fhm_pkg::MODE_PREV:  state_next = fhm_pkg::ST_NAV_RD;
                        default:             state_next = fhm_pkg::ST_IDLE;
                    endcase
                end
            end
            fhm_pkg::ST_REC_RD:   state_next = fhm_pkg::ST_REC_A;
            fhm_pkg::ST_REC_A:    state_next = fhm_pkg::ST_REC_B;
            fhm_pkg::ST_REC_B:    state_next = fhm_pkg::ST_REC_C;
            fhm_pkg::ST_REC_C:    state_next = fhm_pkg::ST_IDLE;
            fhm_pkg::ST_NAV_RD:   state_next = fhm_pkg::ST_NAV_UPD;
            fhm_pkg::ST_NAV_UPD:  state_next = fhm_pkg::ST_OUT_RD;
            fhm_pkg::ST_OUT_RD:   state_next = fhm_pkg::ST_OUT_LOAD;
            fhm_pkg::ST_OUT_LOAD: state_next = fhm_pkg::ST_IDLE;
            default:              state_next = fhm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            fhm_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                cmd.erase   = start && (mode == fhm_pkg::MODE_ERASE);
                cmd.first   = start && (mode == fhm_pkg::MODE_FIRST);
            end
            fhm_pkg::ST_REC_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_rec = 1'b1;
            end
            fhm_pkg::ST_REC_A:
            begin
                cmd.rd_rec = 1'b1;
                cmd.rec_a  = 1'b1;
            end
            fhm_pkg::ST_REC_B:
            begin
                cmd.rd_rec = 1'b1;
                cmd.rec_b  = 1'b1;
            end
            fhm_pkg::ST_REC_C:
            begin
                cmd.rd_rec = 1'b1;
                cmd.rec_c  = 1'b1;
            end
            fhm_pkg::ST_NAV_RD:   cmd.rd_en    = 1'b1;
            fhm_pkg::ST_NAV_UPD:  cmd.nav_upd  = 1'b1;
            fhm_pkg::ST_OUT_RD:   cmd.rd_en    = 1'b1;
            fhm_pkg::ST_OUT_LOAD: cmd.out_load = 1'b1;
            default:              busy         = 1'b1;
        endcase
    end

endmodule

FILE: design/fhm_dp.sv
// Datapath of the fault history log: link, count and record memories, head and cursor.
module fhm_dp #(
    parameter int FAULT_COUNT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fhm_pkg::cmd_t      cmd,
    output fhm_pkg::sts_t      sts,
    input  logic [2:0]         mode,
    input  logic [7:0]         fault_id,
    input  logic [11:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    input  logic [6:0]         floor_number,
    input  logic               motor_stopped,
    input  logic [7:0]         drive_state,
    input  logic signed [15:0] current_d,
    input  logic signed [15:0] current_q,
    output logic               done,
    output logic [7:0]         view_fault,
    output logic [7:0]         view_position,
    output logic [15:0]        occurrence_count,
    output logic [7:0]         year_offset,
    output logic [3:0]         stored_month,
    output logic [4:0]         stored_day,
    output logic [4:0]         stored_hour,
    output logic [5:0]         stored_minute,
    output logic [7:0]         floor_code,
    output logic [7:0]         stored_drive_state,
    output logic signed [15:0] stored_current_d,
    output logic signed [15:0] stored_current_q
);

    localparam int         AW  = $clog2(FAULT_COUNT);
    localparam logic [7:0] FC8 = 8'(FAULT_COUNT);

    logic [7:0]  next_mem [FAULT_COUNT];
    logic [7:0]  prev_mem [FAULT_COUNT];
    logic [15:0] cnt_mem  [FAULT_COUNT];
    fhm_pkg::rec_t rec_mem [FAULT_COUNT];

    logic [FAULT_COUNT-1:0] vld_reg;
    logic [7:0]  head_reg;
    logic [7:0]  cursor_reg;
    logic [7:0]  pos_reg;
    logic        done_reg;
    logic [2:0]  mode_reg;
    logic [7:0]  id_reg;
    fhm_pkg::rec_t rec_in_reg;
    logic [7:0]  n_reg;
    logic [7:0]  p_reg;
    logic [15:0] cnt_reg;

    logic [7:0]  next_rd_reg;
    logic [7:0]  prev_rd_reg;
    logic [15:0] cnt_rd_reg;
    fhm_pkg::rec_t rec_rd_reg;

    logic [7:0]  raddr;
    logic        rd_ok;
    logic [7:0]  next_m;
    logic [7:0]  prev_m;
    logic        id_ne_head;
    logic        head_ok;
    logic        cursor_ok;
    logic [11:0] year_diff;
    fhm_pkg::rec_t rec_in;

    logic        next_we;
    logic [7:0]  next_wa;
    logic [7:0]  next_wd;
    logic        prev_we;
    logic [7:0]  prev_wa;
    logic [7:0]  prev_wd;

    assign sts.id_ok = fault_id < FC8;

    assign raddr      = cmd.rd_rec ? id_reg : cursor_reg;
    assign rd_ok      = (raddr < FC8) && vld_reg[raddr[AW-1:0]];
    assign next_m     = rd_ok ? next_rd_reg : fhm_pkg::NO_ENTRY;
    assign prev_m     = rd_ok ? prev_rd_reg : fhm_pkg::NO_ENTRY;
    assign id_ne_head = id_reg != head_reg;
    assign head_ok    = head_reg < FC8;
    assign cursor_ok  = cursor_reg < FC8;

    assign year_diff = year - fhm_pkg::YEAR_BASE;

    always_comb
    begin
        rec_in = '0;
        if (year > fhm_pkg::YEAR_BASE)
        begin
            rec_in.year_offset = (year_diff > 12'(fhm_pkg::YEAR_MAX)) ? fhm_pkg::YEAR_MAX
                                                                   : year_diff[7:0];
        end
        rec_in.month       = month;
        rec_in.day         = day;
        rec_in.hour        = hour;
        rec_in.minute      = minute;
        rec_in.floor_code  = {motor_stopped, floor_number};
        rec_in.drive_state = drive_state;
        rec_in.current_d   = current_d;
        rec_in.current_q   = current_q;
    end

    // link write ports: unlink in phase A, relink in phases B and C
    always_comb
    begin
        next_we = 1'b0;
        next_wa = id_reg;
        next_wd = fhm_pkg::NO_ENTRY;
        prev_we = 1'b0;
        prev_wa = id_reg;
        prev_wd = fhm_pkg::NO_ENTRY;
        if (cmd.rec_a)
        begin
            next_we = id_ne_head && (prev_m < FC8);
            next_wa = prev_m;
            next_wd = next_m;
            prev_we = id_ne_head && (next_m < FC8);
            prev_wa = next_m;
            prev_wd = prev_m;
        end
        else if (cmd.rec_b)
        begin
            next_we = 1'b1;
            if (id_ne_head)
            begin
                next_wd = head_reg;
            end
            else
            begin
                next_wd = (n_reg == id_reg) ? fhm_pkg::NO_ENTRY : n_reg;
            end
            prev_we = 1'b1;
            prev_wd = id_ne_head ? fhm_pkg::NO_ENTRY : p_reg;
        end
        else if (cmd.rec_c)
        begin
            prev_we = id_ne_head && head_ok;
            prev_wa = head_reg;
            prev_wd = id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa[AW-1:0]] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa[AW-1:0]] <= prev_wd;
        end
        if (cmd.rec_c)
        begin
            cnt_mem[id_reg[AW-1:0]] <= cnt_reg + 16'd1;
            rec_mem[id_reg[AW-1:0]] <= rec_in_reg;
        end
        if (cmd.rd_en)
        begin
            next_rd_reg <= next_mem[raddr[AW-1:0]];
            prev_rd_reg <= prev_mem[raddr[AW-1:0]];
            cnt_rd_reg  <= cnt_mem[raddr[AW-1:0]];
            rec_rd_reg  <= rec_mem[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            id_reg     <= fault_id;
            rec_in_reg <= rec_in;
        end
        if (cmd.rec_a)
        begin
            n_reg   <= next_m;
            p_reg   <= prev_m;
            cnt_reg <= rd_ok ? cnt_rd_reg : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            head_reg   <= fhm_pkg::NO_ENTRY;
            cursor_reg <= fhm_pkg::NO_ENTRY;
            pos_reg    <= 8'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_load;
            if (cmd.erase)
            begin
                vld_reg  <= '0;
                head_reg <= fhm_pkg::NO_ENTRY;
            end
            else if (cmd.rec_c)
            begin
                vld_reg[id_reg[AW-1:0]] <= 1'b1;
                head_reg                <= id_reg;
            end
            if (cmd.first)
            begin
                pos_reg    <= 8'd0;
                cursor_reg <= head_ok ? head_reg : fhm_pkg::NO_ENTRY;
            end
            else if (cmd.nav_upd)
            begin
                if (mode_reg == fhm_pkg::MODE_NEXT)
                begin
                    if (next_m < FC8)
                    begin
                        cursor_reg <= next_m;
                        pos_reg    <= pos_reg + 8'd1;
                    end
                end
                else if (prev_m < FC8)
                begin
                    cursor_reg <= prev_m;
                    if (pos_reg != 8'd0)
                    begin
                        pos_reg <= pos_reg - 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            view_position <= pos_reg;
            if (cursor_ok)
            begin
                view_fault         <= cursor_reg;
                occurrence_count   <= rd_ok ? cnt_rd_reg : 16'd0;
                year_offset        <= rec_rd_reg.year_offset;
                stored_month       <= rec_rd_reg.month;
                stored_day         <= rec_rd_reg.day;
                stored_hour        <= rec_rd_reg.hour;
                stored_minute      <= rec_rd_reg.minute;
                floor_code         <= rec_rd_reg.floor_code;
                stored_drive_state <= rec_rd_reg.drive_state;
                stored_current_d   <= rec_rd_reg.current_d;
                stored_current_q   <= rec_rd_reg.current_q;
            end
            else
            begin
                view_fault         <= fhm_pkg::NO_ENTRY;
                occurrence_count   <= 16'd0;
                year_offset        <= 8'd0;
                stored_month       <= 4'd0;
                stored_day         <= 5'd0;
                stored_hour        <= 5'd0;
                stored_minute      <= 6'd0;
                floor_code         <= 8'd0;
                stored_drive_state <= 8'd0;
                stored_current_d   <= 16'sd0;
                stored_current_q   <= 16'sd0;
            end
        end
    end

    assign done = done_reg;

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < FC8 || head_reg == fhm_pkg::NO_ENTRY)
        else $error("head outside the entry range");

    a_head_linked: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < FC8 |-> vld_reg[head_reg[AW-1:0]])
        else $error("head entry not in the list");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held beyond one cycle");

    a_done_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> done_reg)
        else $error("result load without strobe");

endmodule

FILE: design/fault_history_mru_log_core.sv
// Top level of the most-recent-first fault history log.
//
// An item is taken on a rising edge with start high and busy low; mode selects
// record (0), erase (1), view first (2), view next (3) or view previous (4).
// Record and erase give no result; views give one result, shown for one cycle
// with done high. The receiver cannot hold results off.
// A valid record holds busy while it reads the entry, unlinks, relinks and
// writes count and snapshot; the next item is taken once busy is low again.
// An out-of-range record, an erase or an unused mode leaves busy low.
// View first: the head entry is read, then loaded into the result registers.
// View next/previous: the link read and cursor update are followed by the
// record read on the single memory read port, then by the result load.
// A new item may be taken in the cycle done is high.
// Erase clears the list at once through per-entry flags.
// Reset: list empty, all counts zero, cursor at no entry and position 0;
// snapshots read back undefined until their fault is first recorded.
module fault_history_mru_log_core #(
    parameter int FAULT_COUNT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic [7:0]         fault_id,
    input  logic [11:0]        year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    input  logic [6:0]         floor_number,
    input  logic               motor_stopped,
    input  logic [7:0]         drive_state,
    input  logic signed [15:0] current_d,
    input  logic signed [15:0] current_q,
    output logic               done,
    output logic [7:0]         view_fault,
    output logic [7:0]         view_position,
    output logic [15:0]        occurrence_count,
    output logic [7:0]         year_offset,
    output logic [3:0]         stored_month,
    output logic [4:0]         stored_day,
    output logic [4:0]         stored_hour,
    output logic [5:0]         stored_minute,
    output logic [7:0]         floor_code,
    output logic [7:0]         stored_drive_state,
    output logic signed [15:0] stored_current_d,
    output logic signed [15:0] stored_current_q
);

    fhm_pkg::cmd_t cmd;
    fhm_pkg::sts_t sts;

    fhm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    fhm_dp #(
        .FAULT_COUNT (FAULT_COUNT)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .mode               (mode),
        .fault_id           (fault_id),
        .year               (year),
        .month              (month),
        .day                (day),
        .hour               (hour),
        .minute             (minute),
        .floor_number       (floor_number),
        .motor_stopped      (motor_stopped),
        .drive_state        (drive_state),
        .current_d          (current_d),
        .current_q          (current_q),
        .done               (done),
        .view_fault         (view_fault),
        .view_position      (view_position),
        .occurrence_count   (occurrence_count),
        .year_offset        (year_offset),
        .stored_month       (stored_month),
        .stored_day         (stored_day),
        .stored_hour        (stored_hour),
        .stored_minute      (stored_minute),
        .floor_code         (floor_code),
        .stored_drive_state (stored_drive_state),
        .stored_current_d   (stored_current_d),
        .stored_current_q   (stored_current_q)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the most-recent-first fault history log.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FAULT_COUNT = 32;
    localparam int CYCLE_LIMIT = 50_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 200;
    localparam int WRAP_LOOPS = 260;
    localparam logic [2:0] MODE_TOP = '1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         fid;
        logic [11:0]        yr;
        logic [3:0]         mon;
        logic [4:0]         dy;
        logic [4:0]         hr;
        logic [5:0]         mi;
        logic [6:0]         flr;
        logic               stopped;
        logic [7:0]         drv;
        logic signed [15:0] cur_d;
        logic signed [15:0] cur_q;
    } log_item_t;

    typedef struct packed {
        logic [7:0]     fault;
        logic [7:0]     position;
        logic [15:0]    count;
        fhm_pkg::rec_t  rec;
    } view_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         mode;
    logic [7:0]         fault_id;
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [6:0]         floor_number;
    logic               motor_stopped;
    logic [7:0]         drive_state;
    logic signed [15:0] current_d;
    logic signed [15:0] current_q;
    logic               done;
    logic [7:0]         view_fault;
    logic [7:0]         view_position;
    logic [15:0]        occurrence_count;
    logic [7:0]         year_offset;
    logic [3:0]         stored_month;
    logic [4:0]         stored_day;
    logic [4:0]         stored_hour;
    logic [5:0]         stored_minute;
    logic [7:0]         floor_code;
    logic [7:0]         stored_drive_state;
    logic signed [15:0] stored_current_d;
    logic signed [15:0] stored_current_q;

    fault_history_mru_log_core #(
        .FAULT_COUNT(FAULT_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .fault_id(fault_id),
        .year(year),
        .month(month),
        .day(day),
        .hour(hour),
        .minute(minute),
        .floor_number(floor_number),
        .motor_stopped(motor_stopped),
        .drive_state(drive_state),
        .current_d(current_d),
        .current_q(current_q),
        .done(done),
        .view_fault(view_fault),
        .view_position(view_position),
        .occurrence_count(occurrence_count),
        .year_offset(year_offset),
        .stored_month(stored_month),
        .stored_day(stored_day),
        .stored_hour(stored_hour),
        .stored_minute(stored_minute),
        .floor_code(floor_code),
        .stored_drive_state(stored_drive_state),
        .stored_current_d(stored_current_d),
        .stored_current_q(stored_current_q)
    );

    // Predicted log contents
    logic [7:0]    head_id;
    logic [7:0]    older_link [FAULT_COUNT];
    logic [7:0]    newer_link [FAULT_COUNT];
    logic [15:0]   hits [FAULT_COUNT];
    fhm_pkg::rec_t snap [FAULT_COUNT];
    logic [7:0]    cur_id;
    logic [7:0]    cur_pos;

    view_t expected_views [$];
    int    failures = 0;
    bit    start_on = 1'b0;
    int    burst_left = 1;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit id_ok(logic [7:0] id);
        return int'(id) < FAULT_COUNT;
    endfunction

    function automatic void clear_links();
        head_id = fhm_pkg::NO_ENTRY;
        for (int i = 0; i < FAULT_COUNT; i++)
        begin
            older_link[i] = fhm_pkg::NO_ENTRY;
            newer_link[i] = fhm_pkg::NO_ENTRY;
            hits[i] = '0;
        end
    endfunction

    function automatic void record_fault(log_item_t it);
        logic [7:0]    p;
        logic [7:0]    n;
        logic [11:0]   diff;
        fhm_pkg::rec_t r;
        if (!id_ok(it.fid))
            return;
        if (it.fid != head_id)
        begin
            p = newer_link[it.fid];
            n = older_link[it.fid];
            if (id_ok(p))
                older_link[p] = n;
            if (id_ok(n))
                newer_link[n] = p;
            older_link[it.fid] = head_id;
            newer_link[it.fid] = fhm_pkg::NO_ENTRY;
            if (id_ok(head_id))
                newer_link[head_id] = it.fid;
            head_id = it.fid;
        end
        if (older_link[it.fid] == it.fid)
            older_link[it.fid] = fhm_pkg::NO_ENTRY;
        hits[it.fid] = hits[it.fid] + 16'd1;
        diff = (it.yr > fhm_pkg::YEAR_BASE) ? it.yr - fhm_pkg::YEAR_BASE : 12'd0;
        r.year_offset = (diff > 12'(fhm_pkg::YEAR_MAX)) ? fhm_pkg::YEAR_MAX : diff[7:0];
        r.month = it.mon;
        r.day = it.dy;
        r.hour = it.hr;
        r.minute = it.mi;
        r.floor_code = {it.stopped, it.flr};
        r.drive_state = it.drv;
        r.current_d = it.cur_d;
        r.current_q = it.cur_q;
        snap[it.fid] = r;
    endfunction

    // Applies one item to the predicted log; has_view tells whether a result follows
    function automatic void fault_log_step(input log_item_t it, output view_t v,
                                           output bit has_view);
        v = '0;
        has_view = 1'b1;
        case (it.mode)
            fhm_pkg::MODE_RECORD:
            begin
                record_fault(it);
                has_view = 1'b0;
            end
            fhm_pkg::MODE_ERASE:
            begin
                clear_links();
                has_view = 1'b0;
            end
            fhm_pkg::MODE_FIRST:
            begin
                cur_pos = '0;
                cur_id = id_ok(head_id) ? head_id : fhm_pkg::NO_ENTRY;
            end
            fhm_pkg::MODE_NEXT:
            begin
                if (id_ok(cur_id) && id_ok(older_link[cur_id]))
                begin
                    cur_pos = cur_pos + 8'd1;
                    cur_id = older_link[cur_id];
                end
            end
            fhm_pkg::MODE_PREV:
            begin
                if (id_ok(cur_id) && id_ok(newer_link[cur_id]))
                begin
                    if (cur_pos > 0)
                        cur_pos = cur_pos - 8'd1;
                    cur_id = newer_link[cur_id];
                end
            end
            default:
                has_view = 1'b0;
        endcase
        if (!has_view)
            return;
        v.position = cur_pos;
        if (!id_ok(cur_id))
        begin
            v.fault = fhm_pkg::NO_ENTRY;
            return;
        end
        v.fault = cur_id;
        v.count = hits[cur_id];
        v.rec = snap[cur_id];
    endfunction

    function automatic log_item_t any_item(logic [2:0] m, logic [7:0] id);
        log_item_t it;
        it.mode = m;
        it.fid = id;
        it.yr = 12'($urandom_range(0, 4095));
        it.mon = 4'($urandom_range(0, 12));
        it.dy = 5'($urandom_range(0, 31));
        it.hr = 5'($urandom_range(0, 23));
        it.mi = 6'($urandom_range(0, 59));
        it.flr = 7'($urandom_range(0, 127));
        it.stopped = 1'($urandom_range(0, 1));
        it.drv = 8'($urandom);
        it.cur_d = 16'($urandom);
        it.cur_q = 16'($urandom);
        return it;
    endfunction

    task automatic quiet();
        if (start_on)
        begin
            start <= 1'b0;
            start_on = 1'b0;
        end
    endtask

    task automatic send_item(input log_item_t it);
        view_t v;
        bit    has_view;
        mode <= it.mode;
        fault_id <= it.fid;
        year <= it.yr;
        month <= it.mon;
        day <= it.dy;
        hour <= it.hr;
        minute <= it.mi;
        floor_number <= it.flr;
        motor_stopped <= it.stopped;
        drive_state <= it.drv;
        current_d <= it.cur_d;
        current_q <= it.cur_q;
        start <= 1'b1;
        start_on = 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        fault_log_step(it, v, has_view);
        if (has_view)
            expected_views.push_back(v);
        burst_left--;
        if (burst_left <= 0)
        begin
            quiet();
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic send_op(logic [2:0] m, logic [7:0] id);
        send_item(any_item(m, id));
    endtask

    task automatic wait_drain();
        quiet();
        @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        view_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_views.size() == 0)
            begin
                $error("unexpected view result: fault %0d position %0d",
                       view_fault, view_position);
                failures++;
            end
            else
            begin
                want = expected_views.pop_front();
                check_field("view_fault", want.fault, view_fault);
                check_field("view_position", want.position, view_position);
                check_field("occurrence_count", want.count, occurrence_count);
                check_field("year_offset", want.rec.year_offset, year_offset);
                check_field("stored_month", want.rec.month, stored_month);
                check_field("stored_day", want.rec.day, stored_day);
                check_field("stored_hour", want.rec.hour, stored_hour);
                check_field("stored_minute", want.rec.minute, stored_minute);
                check_field("floor_code", want.rec.floor_code, floor_code);
                check_field("stored_drive_state", want.rec.drive_state, stored_drive_state);
                check_field("stored_current_d", want.rec.current_d, stored_current_d);
                check_field("stored_current_q", want.rec.current_q, stored_current_q);
            end
        end
    end

    task automatic test_empty_log();
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        send_op(fhm_pkg::MODE_NEXT, 8'd0);
        send_op(fhm_pkg::MODE_PREV, 8'd0);
        send_op(fhm_pkg::MODE_RECORD, 8'(FAULT_COUNT));
        send_op(fhm_pkg::MODE_RECORD, 8'hFF);
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        for (int k = int'(fhm_pkg::MODE_PREV) + 1; k <= int'(MODE_TOP); k++)
            send_op(3'(k), 8'd1);
        send_op(fhm_pkg::MODE_NEXT, 8'd0);
    endtask

    task automatic test_field_extremes();
        log_item_t it;
        send_op(fhm_pkg::MODE_ERASE, 8'd0);
        it = '0;
        it.mode = fhm_pkg::MODE_RECORD;
        send_item(it);
        it = any_item(fhm_pkg::MODE_RECORD, 8'(FAULT_COUNT - 1));
        it.yr = 12'hFFF;
        it.mon = 4'd12;
        it.dy = 5'd31;
        it.hr = 5'd23;
        it.mi = 6'd59;
        it.flr = 7'h7F;
        it.stopped = 1'b1;
        it.drv = 8'hFF;
        it.cur_d = 16'sh7FFF;
        it.cur_q = 16'sh8000;
        send_item(it);
        // year offset around the base and the saturation point
        it = any_item(fhm_pkg::MODE_RECORD, 8'd5);
        it.yr = fhm_pkg::YEAR_BASE;
        send_item(it);
        it = any_item(fhm_pkg::MODE_RECORD, 8'd7);
        it.yr = fhm_pkg::YEAR_BASE + 12'd1;
        it.cur_d = 16'sh8000;
        it.cur_q = -16'sd1;
        send_item(it);
        it = any_item(fhm_pkg::MODE_RECORD, 8'd8);
        it.yr = fhm_pkg::YEAR_BASE + 12'd255;
        send_item(it);
        it = any_item(fhm_pkg::MODE_RECORD, 8'd6);
        it.yr = fhm_pkg::YEAR_BASE + 12'd256;
        send_item(it);
        send_op(fhm_pkg::MODE_RECORD, 8'd7);
        send_op(fhm_pkg::MODE_RECORD, 8'd7);
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        repeat (6) send_op(fhm_pkg::MODE_NEXT, 8'd0);
        repeat (7) send_op(fhm_pkg::MODE_PREV, 8'd0);
    endtask

    task automatic test_erase_keeps_cursor();
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        send_op(fhm_pkg::MODE_NEXT, 8'd0);
        send_op(fhm_pkg::MODE_ERASE, 8'd0);
        send_op(fhm_pkg::MODE_NEXT, 8'd0);
        send_op(fhm_pkg::MODE_PREV, 8'd0);
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        send_op(fhm_pkg::MODE_RECORD, 8'd10);
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        send_op(fhm_pkg::MODE_ERASE, 8'd0);
        send_op(fhm_pkg::MODE_RECORD, 8'd10);
        send_op(fhm_pkg::MODE_RECORD, 8'd11);
        // previous from position 0 moves to a newer entry but stays at 0
        send_op(fhm_pkg::MODE_PREV, 8'd0);
        send_op(fhm_pkg::MODE_NEXT, 8'd0);
    endtask

    // Each pass moves the cursor entry to the head and steps past it
    task automatic test_position_wrap();
        send_op(fhm_pkg::MODE_ERASE, 8'd0);
        send_op(fhm_pkg::MODE_RECORD, 8'd1);
        send_op(fhm_pkg::MODE_RECORD, 8'd2);
        send_op(fhm_pkg::MODE_FIRST, 8'd0);
        for (int i = 0; i < WRAP_LOOPS; i++)
        begin
            send_op(fhm_pkg::MODE_RECORD, cur_id);
            send_op(fhm_pkg::MODE_NEXT, 8'd0);
        end
    endtask

    task automatic test_random_traffic();
        int         pick;
        logic [7:0] id;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
                id = 8'($urandom_range(0, 7));
            else
                id = 8'($urandom_range(0, FAULT_COUNT - 1));
            if (pick < 36)
                send_op(fhm_pkg::MODE_RECORD, id);
            else if (pick < 40)
                send_op(fhm_pkg::MODE_RECORD, 8'($urandom_range(FAULT_COUNT, 255)));
            else if (pick < 52)
                send_op(fhm_pkg::MODE_FIRST, id);
            else if (pick < 74)
                send_op(fhm_pkg::MODE_NEXT, id);
            else if (pick < 94)
                send_op(fhm_pkg::MODE_PREV, id);
            else if (pick < 97)
                send_op(fhm_pkg::MODE_ERASE, id);
            else
                send_op(3'($urandom_range(int'(fhm_pkg::MODE_PREV) + 1, int'(MODE_TOP))), id);
            if ($urandom_range(0, 49) == 0)
                wait_drain();
        end
    endtask

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= fhm_pkg::MODE_RECORD;
        fault_id <= '0;
        year <= '0;
        month <= '0;
        day <= '0;
        hour <= '0;
        minute <= '0;
        floor_number <= '0;
        motor_stopped <= 1'b0;
        drive_state <= '0;
        current_d <= '0;
        current_q <= '0;
        clear_links();
        cur_id = fhm_pkg::NO_ENTRY;
        cur_pos = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_log();
        test_field_extremes();
        wait_drain();
        test_erase_keeps_cursor();
        test_position_wrap();
        wait_drain();
        test_random_traffic();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/fhm_pkg.sv
design/fhm_ctrl.sv
design/fhm_dp.sv
design/fault_history_mru_log_core.sv
tb/tb_top.sv
